@@ sv/particle_resampling_wheel_macros.svh @@
// assertion macros for the resampling wheel top level
// each use expects signals named clk and rst in its scope
`ifndef PARTICLE_RESAMPLING_WHEEL_MACROS_SVH
`define PARTICLE_RESAMPLING_WHEEL_MACROS_SVH

// same-cycle implication, off while in reset
`define PRW_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prw: same-cycle check failed");

// next-cycle implication, off while in reset
`define PRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prw: next-cycle check failed");

`endif

@@ sv/prw_pkg.sv @@
// shared types, field widths and codes for the resampling wheel
// used by the interfaces, controller, datapath and top level
package prw_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_PARTICLES_DEF = 256;
  localparam int WEIGHT_BITS_DEF   = 16;

  // request and result field widths
  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int START_W  = 8;
  localparam int FRAC_W   = 16;
  localparam int INDEX_W  = 8;

  // configuration port
  localparam int COUNT_REG_W = 9;
  localparam int FACTOR_W    = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PARTICLE_COUNT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RESAMPLE_FACTOR = CFG_INDEX_W'(1);

  localparam logic [COUNT_REG_W-1:0] RESET_COUNT  = 9'd256;
  localparam logic [FACTOR_W-1:0]    RESET_FACTOR = 8'd128;

  // threshold scale: sum^2 is weighed in 256ths
  localparam int RESAMPLE_SHIFT = 8;
  // fraction/65536 times two collapses to one right shift
  localparam int DRAW_SHIFT = FRAC_W - 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DRAW  = 2'd2
  } opcode_t;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_SAMPLE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic write_weight;
    logic scan_start;
    logic scan_issue;
    logic mul_load_sq;
    logic mul_load_rhs;
    logic mul_step;
    logic save_lhs;
    logic begin_finish;
    logic draw_mul;
    logic draw_prep;
    logic walk_step;
    logic emit;
  } prw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_accepted;
    logic op_load;
    logic op_begin;
    logic op_draw;
    logic scan_last;
    logic scan_idle;
    logic mul_done;
    logic walk_stop;
    logic out_free;
  } prw_status_t;

endpackage

@@ sv/prw_if.sv @@
// request and result channel interfaces of the resampling wheel
// depends on prw_pkg for the field widths
interface prw_item_if;
  logic                          valid;
  logic                          ready;
  logic [prw_pkg::OPCODE_W-1:0]  opcode;
  logic [prw_pkg::SLOT_W-1:0]    slot;
  logic [prw_pkg::WEIGHT_W-1:0]  weight;
  logic [prw_pkg::START_W-1:0]   start_index;
  logic [prw_pkg::FRAC_W-1:0]    random_fraction;

  modport source (
    output valid, opcode, slot, weight, start_index, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, weight, start_index, random_fraction,
    output ready
  );
endinterface

interface prw_result_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [prw_pkg::INDEX_W-1:0]  particle_index;
  logic                         resample_needed;
  logic                         last;

  modport source (
    output valid, result_kind, particle_index, resample_needed, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, particle_index, resample_needed, last,
    output ready
  );
endinterface

@@ sv/prw_controller.sv @@
// sequencing state machine of the resampling wheel
// depends on prw_pkg for the command and status structs
module prw_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  prw_pkg::prw_status_t status,
  output prw_pkg::prw_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_MUL_SQ,
    S_MUL_RHS,
    S_DRAW_PREP,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take_item = 1'b1;
        if (status.item_accepted) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.op_load) begin
          cmd.write_weight = 1'b1;
          state_next       = S_IDLE;
        end else if (status.op_begin) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (status.op_draw) begin
          cmd.draw_mul = 1'b1;
          state_next   = S_DRAW_PREP;
        end else begin
          state_next = S_IDLE;
        end
      end
      // one slot read per cycle
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.scan_idle) begin
          cmd.mul_load_sq = 1'b1;
          state_next      = S_MUL_SQ;
        end
      end
      // sum squared, then factor*count*sumsq
      S_MUL_SQ: begin
        if (status.mul_done) begin
          cmd.save_lhs     = 1'b1;
          cmd.mul_load_rhs = 1'b1;
          state_next       = S_MUL_RHS;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_MUL_RHS: begin
        if (status.mul_done) begin
          cmd.begin_finish = 1'b1;
          state_next       = S_EMIT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_DRAW_PREP: begin
        cmd.draw_prep = 1'b1;
        state_next    = S_WALK;
      end
      // one wheel slot per cycle
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_stop) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/prw_datapath.sv @@
// weight memory, scan accumulators, serial multiplier and wheel walk
// depends on prw_pkg and the channel interfaces in prw_if
module prw_datapath #(
  parameter int MAX_PARTICLES = prw_pkg::MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = prw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  prw_item_if.sink                            item,
  prw_result_if.source                        result,
  input  logic                                cfg_write,
  input  logic [prw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [prw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  prw_pkg::prw_cmd_t                   cmd,
  output prw_pkg::prw_status_t                status
);

  localparam int IDX_W    = $clog2(MAX_PARTICLES);
  localparam int CNT_W    = $clog2(MAX_PARTICLES + 1);
  localparam int SQR_W    = 2 * WEIGHT_BITS;
  localparam int SUM_W    = WEIGHT_BITS + CNT_W;
  localparam int SQ_W     = SQR_W + CNT_W;
  localparam int FN_W     = prw_pkg::FACTOR_W + CNT_W;
  localparam int LHS_W    = 2 * SUM_W + prw_pkg::RESAMPLE_SHIFT;
  localparam int RHS_W    = FN_W + SQ_W;
  localparam int PROD_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int MB_W     = (SUM_W > FN_W) ? SUM_W : FN_W;
  localparam int MCNT_W   = $clog2(MB_W + 1);
  localparam int BETA_W   = WEIGHT_BITS + 2;
  localparam int DPROD_W  = prw_pkg::FRAC_W + WEIGHT_BITS;
  localparam int STEP_W   = $clog2(3 * MAX_PARTICLES + 1);
  localparam int START_W  = prw_pkg::START_W;
  localparam int CREG_W   = prw_pkg::COUNT_REG_W;
  localparam int CMPS_W   = (START_W > CNT_W) ? START_W : CNT_W;
  localparam int CMPC_W   = (CREG_W > CNT_W) ? CREG_W : CNT_W;
  localparam int OUT_IDX_W = prw_pkg::INDEX_W;

  // configuration registers
  logic [CREG_W-1:0]             particle_count;
  logic [prw_pkg::FACTOR_W-1:0]  resample_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count  <= prw_pkg::RESET_COUNT;
      resample_factor <= prw_pkg::RESET_FACTOR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        prw_pkg::REG_PARTICLE_COUNT:  particle_count  <= cfg_data[CREG_W-1:0];
        prw_pkg::REG_RESAMPLE_FACTOR: resample_factor <= cfg_data[prw_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // count in use, clamped to 1..MAX_PARTICLES
  logic [CNT_W-1:0] n;
  always_comb begin
    if (particle_count == '0) begin
      n = CNT_W'(1);
    end else if (CMPC_W'(particle_count) > CMPC_W'(MAX_PARTICLES)) begin
      n = CNT_W'(MAX_PARTICLES);
    end else begin
      n = CNT_W'(particle_count);
    end
  end

  // request capture
  logic                          accepted;
  logic [prw_pkg::OPCODE_W-1:0]  op_r;
  logic [prw_pkg::SLOT_W-1:0]    slot_r;
  logic [prw_pkg::WEIGHT_W-1:0]  weight_r;
  logic [START_W-1:0]            start_r;
  logic [prw_pkg::FRAC_W-1:0]    frac_r;

  assign item.ready = cmd.take_item;
  assign accepted   = item.valid && cmd.take_item;

  always_ff @(posedge clk) begin
    if (accepted) begin
      op_r     <= item.opcode;
      slot_r   <= item.slot;
      weight_r <= item.weight;
      start_r  <= item.start_index;
      frac_r   <= item.random_fraction;
    end
  end

  // weight memory, one write and one registered read port
  logic [WEIGHT_BITS-1:0] weight_mem [MAX_PARTICLES];
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [IDX_W-1:0]       rd_addr;
  logic                   slot_in_range;

  assign slot_in_range = (32'(slot_r) < MAX_PARTICLES);

  always_ff @(posedge clk) begin
    if (cmd.write_weight && slot_in_range) begin
      weight_mem[IDX_W'(slot_r)] <= WEIGHT_BITS'(weight_r);
    end
    rd_data <= weight_mem[rd_addr];
  end

  // wheel state
  logic [WEIGHT_BITS-1:0] max_weight_value;
  logic [IDX_W-1:0]       wheel_position;
  logic [BETA_W-1:0]      beta_acc;
  logic [CNT_W-1:0]       draws_done;

  // scan pipeline: address, read data, square
  logic [IDX_W-1:0]       scan_addr;
  logic [IDX_W-1:0]       p1_idx;
  logic                   p1_valid;
  logic                   p2_valid;
  logic [SUM_W-1:0]       scan_sum;
  logic [SQ_W-1:0]        scan_sumsq;
  logic [SQR_W-1:0]       sq;
  logic [WEIGHT_BITS-1:0] scan_max;
  logic [IDX_W-1:0]       scan_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.scan_issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= scan_addr;
    sq     <= SQR_W'(rd_data) * SQR_W'(rd_data);
    if (cmd.scan_start) begin
      scan_addr  <= '0;
      scan_sum   <= '0;
      scan_sumsq <= '0;
      scan_max   <= '0;
      scan_best  <= '0;
    end else begin
      if (cmd.scan_issue) scan_addr <= scan_addr + 1'b1;
      // first maximum wins
      if (p1_valid) begin
        scan_sum <= scan_sum + SUM_W'(rd_data);
        if (rd_data > scan_max) begin
          scan_max  <= rd_data;
          scan_best <= p1_idx;
        end
      end
      if (p2_valid) scan_sumsq <= scan_sumsq + SQ_W'(sq);
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  logic [MCNT_W-1:0] mul_cnt;
  logic [PROD_W-1:0] mul_acc;
  logic [PROD_W-1:0] mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [FN_W-1:0]   factor_n;
  logic [PROD_W-1:0] lhs_sh;
  logic              need;

  assign factor_n = FN_W'(resample_factor) * FN_W'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (cmd.mul_load_sq || cmd.mul_load_rhs) begin
      mul_cnt <= MCNT_W'(MB_W);
    end else if (cmd.mul_step) begin
      mul_cnt <= mul_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_lhs) lhs_sh <= mul_acc << prw_pkg::RESAMPLE_SHIFT;
    if (cmd.mul_load_sq) begin
      mul_acc <= '0;
      mul_a   <= PROD_W'(scan_sum);
      mul_b   <= MB_W'(scan_sum);
    end else if (cmd.mul_load_rhs) begin
      mul_acc <= '0;
      mul_a   <= PROD_W'(scan_sumsq);
      mul_b   <= MB_W'(factor_n);
    end else if (cmd.mul_step) begin
      if (mul_b[0]) mul_acc <= mul_acc + mul_a;
      mul_a <= mul_a << 1;
      mul_b <= mul_b >> 1;
    end
  end

  // 256*sum^2 <= factor*n*sumsq, never on an all-zero sum
  assign need = (scan_sum != '0) && (lhs_sh <= mul_acc);

  // start index clamp and wheel position wrap
  logic [IDX_W-1:0] start_clamped;
  logic [IDX_W-1:0] wrap_pos;

  always_comb begin
    if (CMPS_W'(start_r) >= CMPS_W'(n)) begin
      start_clamped = IDX_W'(n - CNT_W'(1));
    end else begin
      start_clamped = IDX_W'(start_r);
    end
  end

  assign wrap_pos = (CNT_W'(wheel_position) >= n) ? '0 : wheel_position;

  // wheel walk
  logic [DPROD_W-1:0] dprod;
  logic [BETA_W-1:0]  beta;
  logic [IDX_W-1:0]   walk_idx;
  logic [IDX_W-1:0]   next_idx;
  logic [CNT_W-1:0]   idx_inc;
  logic [STEP_W-1:0]  steps;
  logic [STEP_W-1:0]  limit;
  logic               over;
  logic               limit_hit;
  logic               walk_stop;
  logic               walk_end;

  assign idx_inc   = CNT_W'(walk_idx) + CNT_W'(1);
  assign next_idx  = (idx_inc >= n) ? '0 : IDX_W'(idx_inc);
  assign limit     = (STEP_W'(n) << 1) + STEP_W'(n);
  assign over      = beta > BETA_W'(rd_data);
  assign limit_hit = steps >= limit;
  assign walk_stop = !over || limit_hit;
  assign walk_end  = cmd.walk_step && walk_stop;

  always_ff @(posedge clk) begin
    if (cmd.draw_mul) dprod <= DPROD_W'(frac_r) * DPROD_W'(max_weight_value);
    if (cmd.draw_prep) begin
      beta     <= beta_acc + BETA_W'(dprod >> prw_pkg::DRAW_SHIFT);
      walk_idx <= wrap_pos;
      steps    <= '0;
    end else if (cmd.walk_step && !walk_stop) begin
      beta     <= beta - BETA_W'(rd_data);
      walk_idx <= next_idx;
      steps    <= steps + 1'b1;
    end
  end

  // read address: scan slot, speculative next wheel slot, or wheel start
  always_comb begin
    if (cmd.scan_issue) begin
      rd_addr = scan_addr;
    end else if (cmd.walk_step) begin
      rd_addr = next_idx;
    end else begin
      rd_addr = wrap_pos;
    end
  end

  // wheel state updates at begin and at the end of a walk
  always_ff @(posedge clk) begin
    if (rst) begin
      max_weight_value <= '0;
      wheel_position   <= '0;
      beta_acc         <= '0;
      draws_done       <= '0;
    end else if (cmd.begin_finish) begin
      max_weight_value <= scan_max;
      wheel_position   <= start_clamped;
      beta_acc         <= '0;
      draws_done       <= '0;
    end else if (walk_end) begin
      wheel_position <= walk_idx;
      beta_acc       <= over ? '0 : beta;
      if (draws_done < n) draws_done <= draws_done + 1'b1;
    end
  end

  // pending result
  logic             pend_kind;
  logic [IDX_W-1:0] pend_index;
  logic             pend_need;
  logic             pend_last;

  always_ff @(posedge clk) begin
    if (cmd.begin_finish) begin
      pend_kind  <= prw_pkg::KIND_SUMMARY;
      pend_index <= scan_best;
      pend_need  <= need;
      pend_last  <= 1'b0;
    end else if (walk_end) begin
      pend_kind  <= prw_pkg::KIND_SAMPLE;
      pend_index <= walk_idx;
      pend_need  <= 1'b0;
      pend_last  <= (draws_done < n) && (draws_done + CNT_W'(1) == n);
    end
  end

  // output register
  logic             out_valid;
  logic             out_kind;
  logic [IDX_W-1:0] out_index;
  logic             out_need;
  logic             out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= pend_kind;
      out_index <= pend_index;
      out_need  <= pend_need;
      out_last  <= pend_last;
    end
  end

  assign result.valid           = out_valid;
  assign result.result_kind     = out_kind;
  assign result.particle_index  = OUT_IDX_W'(out_index);
  assign result.resample_needed = out_need;
  assign result.last            = out_last;

  // status to the controller
  assign status.item_accepted = accepted;
  assign status.op_load       = (op_r == prw_pkg::OP_LOAD);
  assign status.op_begin      = (op_r == prw_pkg::OP_BEGIN);
  assign status.op_draw       = (op_r == prw_pkg::OP_DRAW);
  assign status.scan_last     = (CNT_W'(scan_addr) == n - CNT_W'(1));
  assign status.scan_idle     = !p1_valid && !p2_valid;
  assign status.mul_done      = (mul_cnt == '0);
  assign status.walk_stop     = walk_stop;
  assign status.out_free      = !out_valid || result.ready;

endmodule

@@ sv/particle_resampling_wheel.sv @@
// top level of the resampling wheel: controller, datapath and checks
// depends on prw_pkg, prw_if, prw_controller, prw_datapath and the macro header
//
// usage
//   item carries requests: load writes a weight into a slot, begin scans the
//   first n slots (n = particle_count clamped to 1..MAX_PARTICLES) and arms
//   the wheel, draw walks the wheel once and names the chosen slot
//   result carries one item for each begin (best index, resample flag) and
//   each draw (chosen index, last flag); loads and opcode 3 give none
//   requests are taken one at a time, ready is high only while waiting
//   a draw walks the slots it passes one per cycle through the weight memory
//   read port; a begin takes one memory read per slot, then the serial
//   multiplier forms both sides of the resample test one bit per cycle
//   a result sits in an output register; while the receiver stalls the next
//   request is still taken and worked on, and only its result waits
//   configuration is written through cfg_write/cfg_index/cfg_data while idle
//   reset clears the wheel state and restores the register defaults; the
//   weight memory is not cleared and slots must be loaded before use
`include "particle_resampling_wheel_macros.svh"

module particle_resampling_wheel #(
  parameter int MAX_PARTICLES = prw_pkg::MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = prw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  prw_item_if.sink                         item,
  prw_result_if.source                     result,
  input  logic                             cfg_write,
  input  logic [prw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  prw_pkg::prw_cmd_t    cmd;
  prw_pkg::prw_status_t status;

  // sequencing
  prw_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // storage and arithmetic
  prw_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  // one request in flight at a time
  `PRW_ASSERT_NEXT(a_one_request, item.valid && item.ready, !item.ready)
  // a result is only loaded when the output register has room
  `PRW_ASSERT_IMPLY(a_emit_room, cmd.emit, status.out_free)
  // the serial multiplier never steps past its last bit
  `PRW_ASSERT_IMPLY(a_mul_bound, cmd.mul_step, !status.mul_done)
  // flags belong to their own result kind
  `PRW_ASSERT_IMPLY(a_kind_flags, result.valid, (result.result_kind == prw_pkg::KIND_SAMPLE) ? !result.resample_needed : !result.last)

endmodule

@@ tb/sv/particle_resampling_wheel_test.sv @@
// self-checking bench for particle_resampling_wheel: directed script, then random rounds
// depends on prw_pkg, prw_if and the particle_resampling_wheel rtl
module particle_resampling_wheel_test;
  import prw_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int SLOTS          = MAX_PARTICLES_DEF;
  localparam int SETTLE_CYCLES  = 20;
  localparam int END_CYCLES     = 1000;      // longer than the slowest walk
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int PHASE_ITEMS    = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 8;
  localparam int FULL_PHASE     = 3;
  localparam int BETA_SPAN      = 2;         // beta steps span up to twice the peak
  localparam int WALK_TURNS     = 3;         // a walk gives up after 3*n slots
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // per-phase register settings; 0 and 300 fall outside 1..256 on purpose
  localparam int unsigned PHASE_COUNT [NUM_PHASES]  = '{8, 1, 16, 256, 0, 3, 300, 5};
  localparam int unsigned PHASE_FACTOR [NUM_PHASES] = '{128, 255, 200, 255, 64, 0, 128, 211};

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [START_W-1:0]  start_index;
    logic [FRAC_W-1:0]   random_fraction;
  } wheel_req_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic               need;
    logic               last;
  } wheel_res_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    wheel_req_t             req;
    logic                   typed;
    logic                   typed_emits;
    wheel_res_t             typed_res;
  } script_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  prw_item_if   req_ch ();
  prw_result_if res_ch ();

  particle_resampling_wheel u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (req_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the wheel state and registers
  logic [WEIGHT_W-1:0]    weight_mem [SLOTS];
  logic [WEIGHT_W-1:0]    peak_weight = '0;
  logic [INDEX_W-1:0]     wheel_idx   = '0;
  logic [17:0]            beta_acc    = '0;
  logic [COUNT_REG_W-1:0] draws_taken = '0;
  logic [COUNT_REG_W-1:0] count_reg   = RESET_COUNT;
  logic [FACTOR_W-1:0]    factor_reg  = RESET_FACTOR;

  wheel_res_t   picks_due [$];
  script_row_t  script [$];
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  phase_items;
  int unsigned  mismatches;
  bit           hold_off;

  // clock
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int unsigned slots_in_use();
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WEIGHT_W'($urandom_range(0, 255));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic wheel_req_t rand_req(input logic [OPCODE_W-1:0] op);
    wheel_req_t rq;
    rq.opcode          = op;
    rq.slot            = SLOT_W'($urandom);
    rq.weight          = rand_weight();
    rq.start_index     = START_W'($urandom);
    rq.random_fraction = FRAC_W'($urandom);
    return rq;
  endfunction

  function automatic script_row_t req_row(input logic [OPCODE_W-1:0] op,
                                          input int unsigned slot, weight, start, frac);
    script_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.req  = '{op, SLOT_W'(slot), WEIGHT_W'(weight), START_W'(start), FRAC_W'(frac)};
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input int unsigned value);
    script_row_t r;
    r = '0;
    r.kind      = ROW_REG;
    r.reg_index = index;
    r.reg_value = CFG_DATA_W'(value);
    return r;
  endfunction

  function automatic script_row_t typed_row(input script_row_t r, input logic emits,
                                            input wheel_res_t res);
    script_row_t t;
    t = r;
    t.typed       = 1'b1;
    t.typed_emits = emits;
    t.typed_res   = res;
    return t;
  endfunction

  // one request through the wheel: write on load, scan on begin, walk on draw
  task automatic turn_wheel(input wheel_req_t rq, output logic emits, output wheel_res_t rs);
    int unsigned n, idx, steps, beta, best, peak;
    longint unsigned total, squares, lhs, rhs, gain;
    n = slots_in_use();
    emits = 1'b0;
    rs = '0;
    case (rq.opcode)
      OP_LOAD: weight_mem[rq.slot] = rq.weight;
      OP_BEGIN: begin
        total = 0;
        squares = 0;
        best = 0;
        peak = 0;
        // sum, sum of squares, first maximum
        for (int i = 0; i < n; i++) begin
          total += weight_mem[i];
          squares += 64'(weight_mem[i]) * weight_mem[i];
          if (weight_mem[i] > peak) begin
            peak = weight_mem[i];
            best = i;
          end
        end
        // 256*sum^2 <= factor*n*sumsq, never with an empty sum
        lhs = (total * total) << RESAMPLE_SHIFT;
        rhs = squares * n * factor_reg;
        peak_weight = WEIGHT_W'(peak);
        wheel_idx   = INDEX_W'((rq.start_index >= n) ? n - 1 : rq.start_index);
        beta_acc    = '0;
        draws_taken = '0;
        emits    = 1'b1;
        rs.kind  = KIND_SUMMARY;
        rs.index = INDEX_W'(best);
        rs.need  = (total != 0) && (lhs <= rhs);
      end
      OP_DRAW: begin
        // position left beyond a shrunken count restarts at slot 0
        idx = wheel_idx;
        if (idx >= n) idx = 0;
        gain = (64'(rq.random_fraction) * BETA_SPAN * peak_weight) >> FRAC_W;
        beta = beta_acc + 32'(gain);
        steps = 0;
        while (beta > weight_mem[idx]) begin
          if (steps >= WALK_TURNS * n) begin
            beta = 0;
            break;
          end
          beta -= weight_mem[idx];
          idx = (idx + 1 >= n) ? 0 : idx + 1;
          steps++;
        end
        wheel_idx = INDEX_W'(idx);
        beta_acc  = 18'(beta);
        if (draws_taken < n) begin
          draws_taken++;
          rs.last = (draws_taken == n);
        end
        emits    = 1'b1;
        rs.kind  = KIND_SAMPLE;
        rs.index = INDEX_W'(idx);
      end
      default: ;
    endcase
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got)
      report($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
  endtask

  // compare one accepted result with the oldest prediction
  task automatic take_result();
    wheel_res_t due;
    if (picks_due.size() == 0) begin
      report($sformatf("result with nothing pending: kind %0d index %0d need %0d last %0d",
                       res_ch.result_kind, res_ch.particle_index,
                       res_ch.resample_needed, res_ch.last));
    end else begin
      due = picks_due.pop_front();
      check_field("result_kind", due.kind, res_ch.result_kind);
      check_field("particle_index", due.index, res_ch.particle_index);
      check_field("resample_needed", due.need, res_ch.resample_needed);
      check_field("last", due.last, res_ch.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) take_result();
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one request, wait for it to be taken, then predict its result
  task automatic send_request(input wheel_req_t rq, input logic typed, typed_emits,
                              input wheel_res_t typed_res);
    logic emits;
    wheel_res_t rs;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= rq.opcode;
    req_ch.slot            <= rq.slot;
    req_ch.weight          <= rq.weight;
    req_ch.start_index     <= rq.start_index;
    req_ch.random_fraction <= rq.random_fraction;
    do @(posedge clk); while (!req_ch.ready);
    turn_wheel(rq, emits, rs);
    if (typed) begin
      emits = typed_emits;
      rs    = typed_res;
    end
    if (emits) picks_due.push_back(rs);
    if (rq.opcode != OP_UNUSED) phase_items++;
  endtask

  // stop offering and wait until every pending result is back
  task automatic drain(input int unsigned settle);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (index == REG_PARTICLE_COUNT) count_reg = COUNT_REG_W'(value);
    else factor_reg = FACTOR_W'(value);
  endtask

  // loads, a begin, then a run of draws with the odd reload in between
  task automatic run_round(input bit full);
    int unsigned n, loads, draws;
    wheel_req_t rq;
    n = slots_in_use();
    loads = $urandom_range(0, (n < 6) ? n : 6);
    repeat (loads) begin
      rq = rand_req(OP_LOAD);
      rq.slot = SLOT_W'($urandom_range(0, n - 1));
      send_request(rq, 1'b0, 1'b0, '0);
    end
    rq = rand_req(OP_BEGIN);
    if ($urandom_range(0, 4) != 0) rq.start_index = START_W'($urandom_range(0, n - 1));
    send_request(rq, 1'b0, 1'b0, '0);
    draws = (full || n <= 16) ? n + $urandom_range(0, 2) : $urandom_range(4, 12);
    repeat (draws) begin
      if ($urandom_range(0, 19) == 0) send_request(rand_req(OP_LOAD), 1'b0, 1'b0, '0);
      send_request(rand_req(OP_DRAW), 1'b0, 1'b0, '0);
    end
  endtask

  // stray requests outside a round
  task automatic run_noise();
    case ($urandom_range(0, 3))
      0: send_request(rand_req(OP_UNUSED), 1'b0, 1'b0, '0);
      1: send_request(rand_req(OP_DRAW), 1'b0, 1'b0, '0);
      2: send_request(rand_req(OP_BEGIN), 1'b0, 1'b0, '0);
      default: send_request(rand_req(OP_LOAD), 1'b0, 1'b0, '0);
    endcase
  endtask

  // stimulus
  initial begin
    wheel_req_t rq;
    bit first_round;
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = '0;
    req_ch.slot            = '0;
    req_ch.weight          = '0;
    req_ch.start_index     = '0;
    req_ch.random_fraction = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    phase_items = 0;
    mismatches  = 0;
    hold_off    = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // every slot gets a weight before anything reads it
    for (int s = 0; s < SLOTS; s++) begin
      rq = rand_req(OP_LOAD);
      rq.slot = SLOT_W'(s);
      send_request(rq, 1'b0, 1'b0, '0);
    end

    // draw before any begin: zero peak, zero beta, slot 0
    script.push_back(typed_row(req_row(OP_DRAW, 0, 0, 0, 'hFFFF), 1'b1,
                               '{KIND_SAMPLE, 8'd0, 1'b0, 1'b0}));
    script.push_back(typed_row(req_row(OP_UNUSED, 'hFF, 'hFFFF, 'hFF, 'hFFFF), 1'b0, '0));
    script.push_back(req_row(OP_BEGIN, 0, 0, 255, 0));
    script.push_back(typed_row(req_row(OP_DRAW, 0, 0, 0, 0), 1'b1,
                               '{KIND_SAMPLE, 8'd255, 1'b0, 1'b0}));
    // count shrunk under the wheel position, zero count acts as one
    script.push_back(reg_row(REG_PARTICLE_COUNT, 0));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 0));
    script.push_back(reg_row(REG_PARTICLE_COUNT, 4));
    script.push_back(reg_row(REG_RESAMPLE_FACTOR, 255));
    script.push_back(req_row(OP_LOAD, 0, 0, 0, 0));
    script.push_back(req_row(OP_LOAD, 1, 'hFFFF, 0, 0));
    script.push_back(req_row(OP_LOAD, 2, 'hFFFF, 0, 0));
    script.push_back(req_row(OP_LOAD, 3, 1, 0, 0));
    // start beyond count saturates, tie for maximum keeps the first
    script.push_back(req_row(OP_BEGIN, 0, 0, 200, 0));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 0));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 'hFFFF));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 'h8000));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 'hFFFF));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 1));
    // zeroed weights under a stale peak stall the walk
    for (int s = 0; s < 4; s++) script.push_back(req_row(OP_LOAD, s, 0, 0, 0));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 'hFFFF));
    script.push_back(typed_row(req_row(OP_BEGIN, 0, 0, 0, 0), 1'b1,
                               '{KIND_SUMMARY, 8'd0, 1'b0, 1'b0}));
    script.push_back(req_row(OP_LOAD, 255, 'hFFFF, 0, 0));
    // count above the store size acts as the store size
    script.push_back(reg_row(REG_PARTICLE_COUNT, 511));
    script.push_back(reg_row(REG_RESAMPLE_FACTOR, 0));
    script.push_back(req_row(OP_BEGIN, 0, 0, 17, 0));
    script.push_back(req_row(OP_DRAW, 0, 0, 0, 'hFFFF));

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain(SETTLE_CYCLES);
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        send_request(script[i].req, script[i].typed, script[i].typed_emits,
                     script[i].typed_res);
      end
    end

    // random phases, each under its own settings and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(SETTLE_CYCLES);
      write_reg(REG_PARTICLE_COUNT, PHASE_COUNT[p]);
      write_reg(REG_RESAMPLE_FACTOR, PHASE_FACTOR[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      if (p == 0) hold_off = 1'b1;
      phase_items = 0;
      first_round = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          run_noise();
        end else begin
          run_round(p == FULL_PHASE && first_round);
          first_round = 1'b0;
        end
      end
    end

    drain(END_CYCLES);
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("** particle_resampling_wheel: PASSED **");
    end else begin
      $display("** particle_resampling_wheel: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("** particle_resampling_wheel: FAILED **");
    $finish;
  end

endmodule
